### src/dsf_pkg.sv
`default_nettype none

package dsf_pkg;

   localparam int FIFO_DEPTH = 32;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = 6;
   localparam int SAMPLE_W   = 8;
   localparam int WORD_W     = 16;
   localparam int ROUTE_W    = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 2;
   localparam int NUM_FIFOS  = 2;

   localparam logic [CNT_W-1:0] WRITE_LIMIT = CNT_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] DMA_LEVEL   = CNT_W'(FIFO_DEPTH / 2);

   typedef enum logic [1:0] {
      KIND_WRITE_A = 2'd0,
      KIND_WRITE_B = 2'd1,
      KIND_TIMER   = 2'd2,
      KIND_CLEAR   = 2'd3
   } dsf_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_A_ROUTING = 2'd0,
      CSR_A_TIMER   = 2'd1,
      CSR_B_ROUTING = 2'd2,
      CSR_B_TIMER   = 2'd3
   } dsf_csr_type;

   typedef struct packed {
      logic load_item;
      logic exec;
      logic write_hi;
      logic pop_capture;
      logic out_load;
   } dsf_cmd_type;

   typedef struct packed {
      dsf_kind_type kind;
      logic         write_ok;
      logic         out_free;
   } dsf_stat_type;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

endpackage

`default_nettype wire

### src/dsf_ram.sv
`default_nettype none

module dsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/dsf_ctrl.sv
`default_nettype none

module dsf_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire dsf_pkg::dsf_stat_type stat,
   output dsf_pkg::dsf_cmd_type       cmd
);

   import dsf_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_EXEC     = 5'b00010,
      ST_WRITE_HI = 5'b00100,
      ST_POP_DATA = 5'b01000,
      ST_DONE     = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if ((stat.kind == KIND_WRITE_A || stat.kind == KIND_WRITE_B) && stat.write_ok) begin
               state_in = ST_WRITE_HI;
            end else if (stat.kind == KIND_TIMER) begin
               state_in = ST_POP_DATA;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_WRITE_HI: begin
            cmd.write_hi = 1'b1;
            state_in     = ST_DONE;
         end
         ST_POP_DATA: begin
            cmd.pop_capture = 1'b1;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == ST_EXEC)
      else $error("accepted beat did not start execution");

   a_write_hi_after_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE_HI |-> $past(state_ff == ST_EXEC))
      else $error("high byte write without preceding exec");

   a_pop_after_exec: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POP_DATA |-> $past(state_ff == ST_EXEC && stat.kind == KIND_TIMER))
      else $error("pop capture without timer exec");

endmodule

`default_nettype wire

### src/dsf_datapath.sv
`default_nettype none

module dsf_datapath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [1:0]                         req_kind,
   input  wire logic [dsf_pkg::WORD_W-1:0]         req_word,
   input  wire logic                               req_timer_id,
   input  wire logic                               req_clear_a,
   input  wire logic                               req_clear_b,
   input  wire logic                               csr_write,
   input  wire logic [dsf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [dsf_pkg::CSR_DATA_W-1:0]     csr_data,
   input  wire dsf_pkg::dsf_cmd_type               cmd,
   output dsf_pkg::dsf_stat_type                   stat,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [dsf_pkg::SAMPLE_W-1:0]     rsp_sample_a,
   output logic signed [dsf_pkg::SAMPLE_W-1:0]     rsp_sample_b,
   output logic                                    rsp_dma_request_a,
   output logic                                    rsp_dma_request_b,
   output logic [dsf_pkg::CNT_W-1:0]               rsp_level_a,
   output logic [dsf_pkg::CNT_W-1:0]               rsp_level_b
);

   import dsf_pkg::*;

   // item registers
   dsf_kind_type        kind_ff;
   logic [WORD_W-1:0]   word_ff;
   logic                timer_ff;
   logic                clr_ff [NUM_FIFOS];

   // configuration
   logic [ROUTE_W-1:0]  routing_ff [NUM_FIFOS];
   logic                timer_sel_ff [NUM_FIFOS];

   // per-FIFO state
   logic [PTR_W-1:0]    rd_ff [NUM_FIFOS];
   logic [PTR_W-1:0]    wr_ff [NUM_FIFOS];
   logic [CNT_W-1:0]    cnt_ff [NUM_FIFOS];
   logic [SAMPLE_W-1:0] held_ff [NUM_FIFOS];
   logic                popped_ff [NUM_FIFOS];
   logic                dma_ff [NUM_FIFOS];
   logic [SAMPLE_W-1:0] rdata [NUM_FIFOS];
   logic                write_ok [NUM_FIFOS];

   // result register
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] out_sample_ff [NUM_FIFOS];
   logic                out_dma_ff [NUM_FIFOS];
   logic [CNT_W-1:0]    out_level_ff [NUM_FIFOS];

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         kind_ff    <= dsf_kind_type'(req_kind);
         word_ff    <= req_word;
         timer_ff   <= req_timer_id;
         clr_ff[0]  <= req_clear_a;
         clr_ff[1]  <= req_clear_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         routing_ff[0]   <= '0;
         routing_ff[1]   <= '0;
         timer_sel_ff[0] <= 1'b0;
         timer_sel_ff[1] <= 1'b0;
      end else if (csr_write) begin
         unique case (dsf_csr_type'(csr_index))
            CSR_A_ROUTING: routing_ff[0]   <= csr_data;
            CSR_A_TIMER:   timer_sel_ff[0] <= csr_data[0];
            CSR_B_ROUTING: routing_ff[1]   <= csr_data;
            CSR_B_TIMER:   timer_sel_ff[1] <= csr_data[0];
            default: ;
         endcase
      end
   end

   for (genvar i = 0; i < NUM_FIFOS; i++) begin : g_fifo
      logic             write_sel;
      logic             pop_sel;
      logic             pop_go;
      logic             wr_en;
      logic [CNT_W-1:0] cnt_after_pop;

      assign write_sel     = (i == 0) ? (kind_ff == KIND_WRITE_A) : (kind_ff == KIND_WRITE_B);
      assign write_ok[i]   = (cnt_ff[i] < WRITE_LIMIT);
      assign pop_sel       = (kind_ff == KIND_TIMER) && (routing_ff[i] != '0)
                             && (timer_sel_ff[i] == timer_ff);
      assign pop_go        = cmd.exec && pop_sel && (cnt_ff[i] != '0);
      assign wr_en         = (cmd.exec || cmd.write_hi) && write_sel && write_ok[i];
      assign cnt_after_pop = (cnt_ff[i] == '0) ? '0 : cnt_ff[i] - CNT_W'(1);

      dsf_ram #(
         .WIDTH (SAMPLE_W),
         .DEPTH (FIFO_DEPTH)
      ) u_store (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_ff[i]),
         .wr_data (cmd.exec ? word_ff[SAMPLE_W-1:0] : word_ff[WORD_W-1:SAMPLE_W]),
         .rd_en   (pop_go),
         .rd_addr (rd_ff[i]),
         .rd_data (rdata[i])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            rd_ff[i]     <= '0;
            wr_ff[i]     <= '0;
            cnt_ff[i]    <= '0;
            held_ff[i]   <= '0;
            popped_ff[i] <= 1'b0;
            dma_ff[i]    <= 1'b0;
         end else begin
            if (cmd.load_item) begin
               dma_ff[i]    <= 1'b0;
               popped_ff[i] <= 1'b0;
            end
            if (cmd.exec) begin
               popped_ff[i] <= pop_go;
               dma_ff[i]    <= pop_sel && (cnt_after_pop <= DMA_LEVEL);
               if (kind_ff == KIND_CLEAR && clr_ff[i]) begin
                  rd_ff[i]  <= '0;
                  wr_ff[i]  <= '0;
                  cnt_ff[i] <= '0;
               end
            end
            if (wr_en) begin
               wr_ff[i] <= next_ptr(wr_ff[i]);
            end
            if (cmd.write_hi && wr_en) begin
               cnt_ff[i] <= cnt_ff[i] + CNT_W'(2);
            end
            if (pop_go) begin
               rd_ff[i]  <= next_ptr(rd_ff[i]);
               cnt_ff[i] <= cnt_after_pop;
            end
            if (cmd.pop_capture && popped_ff[i]) begin
               held_ff[i] <= rdata[i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.out_load) begin
            out_sample_ff[i] <= held_ff[i];
            out_dma_ff[i]    <= dma_ff[i];
            out_level_ff[i]  <= cnt_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      stat.kind     = kind_ff;
      stat.out_free = !rsp_valid_ff || !rsp_stall;
      case (kind_ff)
         KIND_WRITE_A: stat.write_ok = write_ok[0];
         KIND_WRITE_B: stat.write_ok = write_ok[1];
         default:      stat.write_ok = 1'b0;
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_a      = signed'(out_sample_ff[0]);
   assign rsp_sample_b      = signed'(out_sample_ff[1]);
   assign rsp_dma_request_a = out_dma_ff[0];
   assign rsp_dma_request_b = out_dma_ff[1];
   assign rsp_level_a       = out_level_ff[0];
   assign rsp_level_b       = out_level_ff[1];

   a_level_a_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[0] <= CNT_W'(FIFO_DEPTH))
      else $error("FIFO A level beyond depth");

   a_level_b_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[1] <= CNT_W'(FIFO_DEPTH))
      else $error("FIFO B level beyond depth");

   a_dma_only_on_timer: assert property (@(posedge clock) disable iff (reset)
      (dma_ff[0] || dma_ff[1]) |-> kind_ff == KIND_TIMER)
      else $error("DMA request raised for a non-timer beat");

endmodule

`default_nettype wire

### src/direct_sound_fifo_pair.sv
// Direct-sound FIFO pair: two 32-byte sample FIFOs, A and B.
// Request channel (req_valid/req_stall): one beat per bus event. A write beat
// (kind 0 or 1) pushes req_word low byte then high byte unless the FIFO holds
// 31 or more bytes. A timer beat (kind 2) pops one byte into the held sample
// of each routed FIFO bound to req_timer_id. A clear beat (kind 3) empties the
// FIFOs selected by req_clear_a / req_clear_b.
// Response channel (rsp_valid/rsp_stall): exactly one beat per request beat,
// carrying both held samples, the DMA requests and both levels.
// Config channel (csr_valid/csr_ready, always ready): index 0 A routing,
// 1 A timer, 2 B routing, 3 B timer; write only while the block is idle.
// An accepted beat steps through exec, a high-byte write (stored word) or pop
// capture (timer), then done, which loads the response register. A new
// request is taken only in idle: the sequencer needs two single-port byte
// writes for a word, or a registered store read for a pop. The response
// register lets the next request be accepted while a response waits; a
// stalled response holds the sequencer in its final step. Reset empties both
// FIFOs, zeroes the held samples and routing; store contents stay undefined.
`default_nettype none

module direct_sound_fifo_pair (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [1:0]                         req_kind,
   input  wire logic [dsf_pkg::WORD_W-1:0]         req_word,
   input  wire logic                               req_timer_id,
   input  wire logic                               req_clear_a,
   input  wire logic                               req_clear_b,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [dsf_pkg::SAMPLE_W-1:0]     rsp_sample_a,
   output logic signed [dsf_pkg::SAMPLE_W-1:0]     rsp_sample_b,
   output logic                                    rsp_dma_request_a,
   output logic                                    rsp_dma_request_b,
   output logic [dsf_pkg::CNT_W-1:0]               rsp_level_a,
   output logic [dsf_pkg::CNT_W-1:0]               rsp_level_b,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [dsf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [dsf_pkg::CSR_DATA_W-1:0]     csr_data
);

   import dsf_pkg::*;

   dsf_cmd_type  cmd;
   dsf_stat_type stat;

   assign csr_ready = 1'b1;

   dsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   dsf_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_kind          (req_kind),
      .req_word          (req_word),
      .req_timer_id      (req_timer_id),
      .req_clear_a       (req_clear_a),
      .req_clear_b       (req_clear_b),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sample_a      (rsp_sample_a),
      .rsp_sample_b      (rsp_sample_b),
      .rsp_dma_request_a (rsp_dma_request_a),
      .rsp_dma_request_b (rsp_dma_request_b),
      .rsp_level_a       (rsp_level_a),
      .rsp_level_b       (rsp_level_b)
   );

endmodule

`default_nettype wire

### dv/tb.sv
`default_nettype none

module tb;
   import dsf_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int FIFO_A      = 0;
   localparam int FIFO_B      = 1;
   localparam int NUM_PHASES  = 8;
   localparam int PHASE_BEATS = 165;

   typedef struct {
      dsf_kind_type          kind;
      logic [WORD_W-1:0]     word;
      logic                  timer_id;
      logic                  clear_a;
      logic                  clear_b;
   } bus_event_type;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample_a;
      logic signed [SAMPLE_W-1:0] sample_b;
      logic                       dma_a;
      logic                       dma_b;
      logic [CNT_W-1:0]           level_a;
      logic [CNT_W-1:0]           level_b;
   } fifo_status_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [1:0]                    req_kind = '0;
   logic [WORD_W-1:0]             req_word = '0;
   logic                          req_timer_id = 1'b0;
   logic                          req_clear_a = 1'b0;
   logic                          req_clear_b = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [SAMPLE_W-1:0]    rsp_sample_a;
   logic signed [SAMPLE_W-1:0]    rsp_sample_b;
   logic                          rsp_dma_request_a;
   logic                          rsp_dma_request_b;
   logic [CNT_W-1:0]              rsp_level_a;
   logic [CNT_W-1:0]              rsp_level_b;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_IDX_W-1:0]          csr_index = '0;
   logic [CSR_DATA_W-1:0]         csr_data = '0;

   direct_sound_fifo_pair uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_word          (req_word),
      .req_timer_id      (req_timer_id),
      .req_clear_a       (req_clear_a),
      .req_clear_b       (req_clear_b),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sample_a      (rsp_sample_a),
      .rsp_sample_b      (rsp_sample_b),
      .rsp_dma_request_a (rsp_dma_request_a),
      .rsp_dma_request_b (rsp_dma_request_b),
      .rsp_level_a       (rsp_level_a),
      .rsp_level_b       (rsp_level_b),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #10 clock = ~clock;

   // shadow copy of both FIFOs and the routing registers
   logic [SAMPLE_W-1:0] byte_mem [NUM_FIFOS][FIFO_DEPTH];
   logic [PTR_W-1:0]    rd_ptr [NUM_FIFOS];
   logic [PTR_W-1:0]    wr_ptr [NUM_FIFOS];
   logic [CNT_W-1:0]    fill [NUM_FIFOS];
   logic [SAMPLE_W-1:0] held [NUM_FIFOS];
   logic [ROUTE_W-1:0]  route [NUM_FIFOS];
   logic                timer_sel [NUM_FIFOS];

   bus_event_type   event_backlog [$];
   fifo_status_type status_due [$];
   bus_event_type   live_event;

   bit  tx_eager;
   bit  rx_eager;
   int  tx_gap;
   int  stall_left;
   int  errors;
   int  cycle_count;
   int  beats_offered;
   int  beats_sent;
   int  beats_seen;
   int  words_stored;
   int  words_dropped;
   int  pops;
   int  empty_pops;
   int  clears;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic void push_word(int f, logic [WORD_W-1:0] w);
      if (fill[f] < WRITE_LIMIT) begin
         byte_mem[f][wr_ptr[f]] = w[7:0];
         wr_ptr[f] = wr_ptr[f] + 1'b1;
         byte_mem[f][wr_ptr[f]] = w[15:8];
         wr_ptr[f] = wr_ptr[f] + 1'b1;
         fill[f] = fill[f] + 2'd2;
         words_stored++;
      end else begin
         words_dropped++;
      end
   endfunction

   // returns the DMA request for this pop
   function automatic logic pop_byte(int f);
      pops++;
      if (fill[f] != 0) begin
         held[f] = byte_mem[f][rd_ptr[f]];
         rd_ptr[f] = rd_ptr[f] + 1'b1;
         fill[f] = fill[f] - 1'b1;
      end else begin
         empty_pops++;
      end
      return fill[f] <= DMA_LEVEL;
   endfunction

   function automatic fifo_status_type advance_fifos(bus_event_type ev);
      fifo_status_type st;
      st.dma_a = 1'b0;
      st.dma_b = 1'b0;
      case (ev.kind)
         KIND_WRITE_A: push_word(FIFO_A, ev.word);
         KIND_WRITE_B: push_word(FIFO_B, ev.word);
         KIND_TIMER: begin
            if (route[FIFO_A] != 0 && timer_sel[FIFO_A] == ev.timer_id)
               st.dma_a = pop_byte(FIFO_A);
            if (route[FIFO_B] != 0 && timer_sel[FIFO_B] == ev.timer_id)
               st.dma_b = pop_byte(FIFO_B);
         end
         KIND_CLEAR: begin
            clears++;
            for (int f = 0; f < NUM_FIFOS; f++) begin
               if ((f == FIFO_A) ? ev.clear_a : ev.clear_b) begin
                  rd_ptr[f] = '0;
                  wr_ptr[f] = '0;
                  fill[f]   = '0;
               end
            end
         end
      endcase
      st.sample_a = held[FIFO_A];
      st.sample_b = held[FIFO_B];
      st.level_a  = fill[FIFO_A];
      st.level_b  = fill[FIFO_B];
      return st;
   endfunction

   function automatic bus_event_type make_event(dsf_kind_type k, logic [WORD_W-1:0] w,
                                                logic tid, logic ca, logic cb);
      bus_event_type ev;
      ev.kind     = k;
      ev.word     = w;
      ev.timer_id = tid;
      ev.clear_a  = ca;
      ev.clear_b  = cb;
      return ev;
   endfunction

   function automatic bus_event_type random_event(int write_pct);
      int           r;
      dsf_kind_type k;
      r = $urandom_range(0, 99);
      if (r < 3)
         k = KIND_CLEAR;
      else if (r < 3 + write_pct)
         k = $urandom_range(0, 1) ? KIND_WRITE_B : KIND_WRITE_A;
      else
         k = KIND_TIMER;
      return make_event(k, WORD_W'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
   endfunction

   task automatic check_field(string name, logic signed [31:0] want,
                              logic signed [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   task automatic csr_write(dsf_csr_type idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_A_ROUTING: route[FIFO_A]     = val;
         CSR_A_TIMER:   timer_sel[FIFO_A] = val[0];
         CSR_B_ROUTING: route[FIFO_B]     = val;
         CSR_B_TIMER:   timer_sel[FIFO_B] = val[0];
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_setting(int a_route, int a_tmr, int b_route, int b_tmr);
      csr_write(CSR_A_ROUTING, CSR_DATA_W'(a_route));
      csr_write(CSR_A_TIMER,   CSR_DATA_W'(a_tmr));
      csr_write(CSR_B_ROUTING, CSR_DATA_W'(b_route));
      csr_write(CSR_B_TIMER,   CSR_DATA_W'(b_tmr));
   endtask

   task automatic wait_drained();
      while (event_backlog.size() != 0 || req_valid || status_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && beats_sent != beats_offered) begin
         // stalled beat holds
      end else if (tx_gap > 0) begin
         req_valid <= 1'b0;
         tx_gap--;
      end else if (event_backlog.size() > 0) begin
         live_event = event_backlog.pop_front();
         req_kind     <= live_event.kind;
         req_word     <= live_event.word;
         req_timer_id <= live_event.timer_id;
         req_clear_a  <= live_event.clear_a;
         req_clear_b  <= live_event.clear_b;
         req_valid    <= 1'b1;
         beats_offered++;
         tx_gap = tx_eager ? 0 : pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         status_due.push_back(advance_fifos(live_event));
         beats_sent++;
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (!reset && !rx_eager && $urandom_range(0, 3) == 0)
            stall_left = pick_gap();
      end
   end

   // response monitor
   always @(posedge clock) begin
      fifo_status_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_seen++;
         if (status_due.size() == 0) begin
            errors++;
            $display("%0t: response beat with nothing outstanding", $time);
         end else begin
            want = status_due.pop_front();
            check_field("sample_a", 32'(want.sample_a), 32'(rsp_sample_a));
            check_field("sample_b", 32'(want.sample_b), 32'(rsp_sample_b));
            check_field("dma_request_a", 32'(want.dma_a), 32'(rsp_dma_request_a));
            check_field("dma_request_b", 32'(want.dma_b), 32'(rsp_dma_request_b));
            check_field("level_a", 32'(want.level_a), 32'(rsp_level_a));
            check_field("level_b", 32'(want.level_b), 32'(rsp_level_b));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, status_due.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      logic [WORD_W-1:0] edge_words [4];
      int setting_table [6][4];
      int write_mix [NUM_PHASES];

      edge_words    = '{16'h0080, 16'h7FFF, 16'h0000, 16'hFFFF};
      setting_table = '{'{3, 0, 3, 1}, '{1, 1, 2, 1}, '{0, 0, 3, 0},
                        '{2, 0, 0, 1}, '{3, 1, 3, 1}, '{0, 1, 0, 0}};
      write_mix     = '{70, 40, 55, 30, 60, 50, 35, 45};

      for (int f = 0; f < NUM_FIFOS; f++) begin
         rd_ptr[f]    = '0;
         wr_ptr[f]    = '0;
         fill[f]      = '0;
         held[f]      = '0;
         route[f]     = '0;
         timer_sel[f] = 1'b0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // routing off after reset: timer beats pop nothing
      event_backlog.push_back(make_event(KIND_TIMER, 16'hA5A5, 1'b0, 1'b1, 1'b1));
      event_backlog.push_back(make_event(KIND_TIMER, 16'h5A5A, 1'b1, 1'b0, 1'b0));
      wait_drained();

      apply_setting(3, 0, 1, 1);
      event_backlog.push_back(make_event(KIND_CLEAR, 16'hFFFF, 1'b1, 1'b1, 1'b1));
      event_backlog.push_back(make_event(KIND_TIMER, 16'h0000, 1'b0, 1'b0, 1'b0));
      event_backlog.push_back(make_event(KIND_TIMER, 16'hFFFF, 1'b1, 1'b1, 1'b1));
      // fill A to the top; the last word is dropped
      for (int i = 0; i < 17; i++)
         event_backlog.push_back(make_event(KIND_WRITE_A,
            (i < 4) ? edge_words[i] : WORD_W'($urandom), 1'($urandom), 1'b1, 1'b0));
      event_backlog.push_back(make_event(KIND_WRITE_B, 16'h807F, 1'b1, 1'b0, 1'b1));
      event_backlog.push_back(make_event(KIND_TIMER, 16'h1234, 1'b0, 1'b1, 1'b1));
      event_backlog.push_back(make_event(KIND_WRITE_A, 16'hBEEF, 1'b0, 1'b0, 1'b0));
      event_backlog.push_back(make_event(KIND_TIMER, 16'h4321, 1'b1, 1'b0, 1'b0));
      event_backlog.push_back(make_event(KIND_CLEAR, 16'h00FF, 1'b1, 1'b1, 1'b0));
      event_backlog.push_back(make_event(KIND_CLEAR, 16'hFF00, 1'b0, 1'b0, 1'b1));
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p < 6)
            apply_setting(setting_table[p][0], setting_table[p][1],
                          setting_table[p][2], setting_table[p][3]);
         else
            apply_setting($urandom_range(0, 3), $urandom_range(0, 1),
                          $urandom_range(0, 3), $urandom_range(0, 1));
         tx_eager = (p % 3 == 1);
         rx_eager = (p % 4 == 2);
         for (int i = 0; i < PHASE_BEATS; i++)
            event_backlog.push_back(random_event(write_mix[p]));
         wait_drained();
      end

      $display("Ran %0d request beats, %0d responses, over %0d register settings.",
               beats_sent, beats_seen, NUM_PHASES + 2);
      $display("Words stored %0d, dropped on full %0d; pops %0d (%0d empty); clears %0d.",
               words_stored, words_dropped, pops, empty_pops, clears);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
